>>> src/hdm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, register codes and the popcount helper for the
// Hamming descriptor matcher. No dependencies.

package hdm_pkg;

	// Field widths of the item and result words
	localparam int SLOT_W  = 10;
	localparam int WORD_W  = 64;
	localparam int DESC_W  = 256;
	localparam int DIST_W  = 9;
	localparam int INDEX_W = 10;

	// Configuration register widths
	localparam int COUNT_W = 11;
	localparam int LIMIT_W = 9;
	localparam int RATIO_W = 4;

	// APB port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_ACTIVE_COUNT   = 2'd0;
	localparam logic [1:0] REG_DISTANCE_LIMIT = 2'd1;
	localparam logic [1:0] REG_RATIO_MULT     = 2'd2;

	// Reset values
	localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RST   = 11'd0;
	localparam logic [LIMIT_W-1:0] DISTANCE_LIMIT_RST = 9'd30;
	localparam logic [RATIO_W-1:0] RATIO_MULT_RST     = 4'd2;

	// Distance meaning "nothing found"
	localparam logic [DIST_W-1:0] NO_DIST = 9'd256;

	// Item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Default depth of the candidate store
	localparam int MAX_CANDIDATES_DEF = 1024;

	// Commands from controller to datapath
	typedef struct packed {
		logic start;    // capture query word, clear best/second, reset scan counter
		logic load_wr;  // write candidate at slot
		logic issue;    // read candidate at scan counter, advance counter
		logic finish;   // register result, mark winner taken if accepted
	} hdm_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_done;  // every candidate below the count has been read
		logic pipe_busy;  // a candidate is still in the distance pipeline
	} hdm_stat_t;

	// SWAR popcount of a 16-bit slice
	function automatic logic [4:0] popcnt16(input logic [15:0] v);
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		begin
			a = v - ((v >> 1) & 16'h5555);
			b = (a & 16'h3333) + ((a >> 2) & 16'h3333);
			c = (b + (b >> 4)) & 16'h0F0F;
			popcnt16 = c[4:0] + c[12:8];
		end
	endfunction

endpackage

>>> src/hdm_in_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying a load or query word.
// Depends on hdm_pkg.

interface hdm_in_if import hdm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [SLOT_W-1:0] slot;
	logic              taken_in;
	logic [WORD_W-1:0] desc_w0;
	logic [WORD_W-1:0] desc_w1;
	logic [WORD_W-1:0] desc_w2;
	logic [WORD_W-1:0] desc_w3;

	modport source(output valid, mode, slot, taken_in, desc_w0, desc_w1, desc_w2, desc_w3,
		input ready);
	modport sink(input valid, mode, slot, taken_in, desc_w0, desc_w1, desc_w2, desc_w3,
		output ready);
endinterface

>>> src/hdm_out_if.sv
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one match result word.
// Depends on hdm_pkg.

interface hdm_out_if import hdm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] best_index;
	logic [DIST_W-1:0]  best_distance;
	logic [DIST_W-1:0]  second_distance;
	logic               found;
	logic               accepted;

	modport source(output valid, best_index, best_distance, second_distance, found, accepted,
		input ready);
	modport sink(input valid, best_index, best_distance, second_distance, found, accepted,
		output ready);
endinterface

>>> src/hdm_regs.sv
`timescale 1ns / 1ps
// APB configuration registers: active count, distance limit, ratio factor.
// Depends on hdm_pkg.

module hdm_regs import hdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic [COUNT_W-1:0]    active_count,
	output logic [LIMIT_W-1:0]    distance_limit,
	output logic [RATIO_W-1:0]    ratio_mult
);

	logic [COUNT_W-1:0] active_count_q;
	logic [LIMIT_W-1:0] distance_limit_q;
	logic [RATIO_W-1:0] ratio_mult_q;
	logic [1:0]         reg_idx;
	logic               wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q   <= ACTIVE_COUNT_RST;
			distance_limit_q <= DISTANCE_LIMIT_RST;
			ratio_mult_q     <= RATIO_MULT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ACTIVE_COUNT:   active_count_q   <= pwdata[COUNT_W-1:0];
				REG_DISTANCE_LIMIT: distance_limit_q <= pwdata[LIMIT_W-1:0];
				REG_RATIO_MULT:     ratio_mult_q     <= pwdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_ACTIVE_COUNT:   prdata = APB_DATA_W'(active_count_q);
			REG_DISTANCE_LIMIT: prdata = APB_DATA_W'(distance_limit_q);
			REG_RATIO_MULT:     prdata = APB_DATA_W'(ratio_mult_q);
			default:            prdata = '0;
		endcase
	end

	assign active_count   = active_count_q;
	assign distance_limit = distance_limit_q;
	assign ratio_mult     = ratio_mult_q;

endmodule

>>> src/hdm_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, scan and finish of one word at a time and
// owns the result valid flag. Depends on hdm_pkg.

module hdm_ctrl import hdm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_mode,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  hdm_stat_t stat,
	output hdm_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Commands to the datapath
	always_comb begin
		cmd.load_wr = in_fire && (in_mode == MODE_LOAD);
		cmd.start   = in_fire && (in_mode == MODE_QUERY);
		cmd.issue   = (state_q == ST_SCAN) && !stat.scan_done;
		cmd.finish  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	// State and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_done && !stat.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/hdm_datapath.sv
`timescale 1ns / 1ps
// Datapath: candidate and taken-flag memories, scan counter, three-stage
// Hamming distance pipeline, best/second tracking and result register.
// Depends on hdm_pkg.

module hdm_datapath import hdm_pkg::*; #(
	parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hdm_cmd_t           cmd,
	output hdm_stat_t          stat,
	input  logic [SLOT_W-1:0]  slot,
	input  logic               taken_in,
	input  logic [WORD_W-1:0]  desc_w0,
	input  logic [WORD_W-1:0]  desc_w1,
	input  logic [WORD_W-1:0]  desc_w2,
	input  logic [WORD_W-1:0]  desc_w3,
	input  logic [COUNT_W-1:0] active_count,
	input  logic [LIMIT_W-1:0] distance_limit,
	input  logic [RATIO_W-1:0] ratio_mult,
	output logic [INDEX_W-1:0] best_index,
	output logic [DIST_W-1:0]  best_distance,
	output logic [DIST_W-1:0]  second_distance,
	output logic               found,
	output logic               accepted
);

	localparam int IDX_W  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
	localparam int NSLICE = DESC_W / 16;
	localparam int NPART  = 4;
	localparam int PER_PART = NSLICE / NPART;
	localparam int PART_W = 7;
	localparam int PROD_W = RATIO_W + DIST_W;

	logic [DESC_W-1:0] desc_mem  [MAX_CANDIDATES];
	logic              taken_mem [MAX_CANDIDATES];

	logic [DESC_W-1:0] in_desc;
	logic [DESC_W-1:0] qry_desc_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic [IDX_W-1:0]  scan_addr;
	logic [IDX_W-1:0]  slot_addr;
	logic              slot_ok;
	logic [CNT_W-1:0]  count_sat;

	// Pipeline
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [DESC_W-1:0] rd_desc_s1;
	logic              rd_taken_s1;
	logic              vld_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [PART_W-1:0] part_s2 [NPART];
	logic [PART_W-1:0] part_d  [NPART];
	logic              vld_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [DIST_W-1:0] dist_s3;

	// Tracking
	logic [DIST_W-1:0] best_q;
	logic [DIST_W-1:0] second_q;
	logic [IDX_W-1:0]  best_idx_q;

	// Result decision
	logic              fnd;
	logic              acc;
	logic [PROD_W-1:0] ratio_prod;

	// Result register
	logic [INDEX_W-1:0] res_index_q;
	logic [DIST_W-1:0]  res_best_q;
	logic [DIST_W-1:0]  res_second_q;
	logic               res_found_q;
	logic               res_acc_q;

	assign in_desc   = {desc_w3, desc_w2, desc_w1, desc_w0};
	assign scan_addr = scan_cnt_q[IDX_W-1:0];
	assign slot_addr = IDX_W'(slot);
	assign slot_ok   = (32'(slot) < 32'(MAX_CANDIDATES));
	assign count_sat = (32'(active_count) > 32'(MAX_CANDIDATES)) ?
		CNT_W'(MAX_CANDIDATES) : CNT_W'(active_count);

	// Candidate store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_wr && slot_ok) begin
			desc_mem[slot_addr] <= in_desc;
		end
		rd_desc_s1 <= desc_mem[scan_addr];
	end

	// Taken flags: loads and accepted matches share the write port
	always_ff @(posedge clk) begin
		if (cmd.load_wr && slot_ok) begin
			taken_mem[slot_addr] <= taken_in;
		end else if (cmd.finish && acc) begin
			taken_mem[best_idx_q] <= 1'b1;
		end
		rd_taken_s1 <= taken_mem[scan_addr];
	end

	// Query word, count and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_cnt_q <= '0;
		end else if (cmd.start) begin
			count_q    <= count_sat;
			scan_cnt_q <= '0;
		end else if (cmd.issue) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qry_desc_q <= in_desc;
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1 && !rd_taken_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 2: XOR and popcount, four partial sums of 64 bits each
	always_comb begin
		logic [DESC_W-1:0] x;
		x = qry_desc_q ^ rd_desc_s1;
		for (int p = 0; p < NPART; p++) begin
			part_d[p] = PART_W'(popcnt16(x[(p*PER_PART+0)*16 +: 16]))
				+ PART_W'(popcnt16(x[(p*PER_PART+1)*16 +: 16]))
				+ PART_W'(popcnt16(x[(p*PER_PART+2)*16 +: 16]))
				+ PART_W'(popcnt16(x[(p*PER_PART+3)*16 +: 16]));
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		idx_s1  <= scan_addr;
		idx_s2  <= idx_s1;
		part_s2 <= part_d;
		idx_s3  <= idx_s2;
		dist_s3 <= DIST_W'(part_s2[0]) + DIST_W'(part_s2[1])
			+ DIST_W'(part_s2[2]) + DIST_W'(part_s2[3]);
	end

	// Track best and second; first index wins ties
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_q     <= NO_DIST;
			second_q   <= NO_DIST;
			best_idx_q <= '0;
		end else if (vld_s3) begin
			if (dist_s3 < best_q) begin
				second_q   <= best_q;
				best_q     <= dist_s3;
				best_idx_q <= idx_s3;
			end else if (dist_s3 < second_q) begin
				second_q <= dist_s3;
			end
		end
	end

	// Threshold and ratio test
	always_comb begin
		ratio_prod = PROD_W'(ratio_mult) * PROD_W'(best_q);
		fnd = (best_q != NO_DIST);
		acc = fnd && (best_q < distance_limit)
			&& ((ratio_mult == '0) || (PROD_W'(second_q) > ratio_prod));
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_index_q  <= INDEX_W'(best_idx_q);
			res_best_q   <= best_q;
			res_second_q <= second_q;
			res_found_q  <= fnd;
			res_acc_q    <= acc;
		end
	end

	assign stat.scan_done = (scan_cnt_q == count_q);
	assign stat.pipe_busy = vld_s1 || vld_s2 || vld_s3;

	assign best_index      = res_index_q;
	assign best_distance   = res_best_q;
	assign second_distance = res_second_q;
	assign found           = res_found_q;
	assign accepted        = res_acc_q;

endmodule

>>> src/hamming_descriptor_matcher.sv
`timescale 1ns / 1ps
// Top level of the Hamming descriptor matcher: APB registers, controller
// and datapath. Depends on hdm_pkg, hdm_in_if, hdm_out_if and the submodules.
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-------------------------------------
//  items    | sink      | valid/ready          | mode, slot, taken_in, desc_w0..w3
//  results  | source    | valid/ready          | best_index, distances, found, accepted
//  apb      | slave     | psel/penable, pready | active_count, distance_limit, ratio_mult
//
// A load word is written in the cycle it is taken; the next word may follow at once.
// A query holds the input while the scan issues one candidate per cycle into the three
// pipeline stages, waits for them to drain, then finishes and returns to idle.
// Reset clears control state only; the store and taken flags are unknown until loaded.
// A waiting result does not block loads; a query finishing behind it holds until taken.

module hamming_descriptor_matcher import hdm_pkg::*; #(
	parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hdm_in_if.sink                items,
	hdm_out_if.source             results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [COUNT_W-1:0] active_count;
	logic [LIMIT_W-1:0] distance_limit;
	logic [RATIO_W-1:0] ratio_mult;
	hdm_cmd_t           cmd;
	hdm_stat_t          stat;

	assign pready = 1'b1;

	// Configuration registers
	hdm_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.active_count   (active_count),
		.distance_limit (distance_limit),
		.ratio_mult     (ratio_mult)
	);

	// Sequencer
	hdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_mode   (items.mode),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Store, distance pipeline and result register
	hdm_datapath #(
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.slot            (items.slot),
		.taken_in        (items.taken_in),
		.desc_w0         (items.desc_w0),
		.desc_w1         (items.desc_w1),
		.desc_w2         (items.desc_w2),
		.desc_w3         (items.desc_w3),
		.active_count    (active_count),
		.distance_limit  (distance_limit),
		.ratio_mult      (ratio_mult),
		.best_index      (results.best_index),
		.best_distance   (results.best_distance),
		.second_distance (results.second_distance),
		.found           (results.found),
		.accepted        (results.accepted)
	);

`ifndef ASSERT_OFF
	// A new result word only follows a finish command
	a_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !$past(results.valid)) |-> $past(cmd.finish))
		else $error("result word appeared without a finish");

	// No word is taken while a scan is issuing reads
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !items.ready)
		else $error("input ready during scan");

	// Finish only once the distance pipeline has drained
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !stat.pipe_busy)
		else $error("finish with candidates still in flight");

	// An accepted match is always a found one with a real distance
	a_accept_found: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.accepted) |-> (results.found && !results.best_distance[8]))
		else $error("accepted result without a found candidate");
`endif

endmodule

>>> tb/sv/hdm_match_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Hamming descriptor matcher: mirrors the candidate store, taken flags
// and registers, predicts the match for every query word and checks each result word.
// Depends on hdm_pkg, hdm_in_if and hdm_out_if.

module hdm_match_checker import hdm_pkg::*; #(
	parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hdm_in_if                     items,
	hdm_out_if                    results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    fail_count,
	output int                    open_queries
);

	typedef struct packed {
		logic [INDEX_W-1:0] best_index;
		logic [DIST_W-1:0]  best_distance;
		logic [DIST_W-1:0]  second_distance;
		logic               found;
		logic               accepted;
	} match_t;

	logic [DESC_W-1:0]  cand_desc [MAX_CANDIDATES];
	bit                 cand_taken [MAX_CANDIDATES];
	logic [COUNT_W-1:0] scan_count;
	logic [LIMIT_W-1:0] dist_limit;
	logic [RATIO_W-1:0] ratio;
	match_t             pending_matches [$];
	match_t             seen;
	match_t             want;
	match_t             predicted;
	int                 failures = 0;
	int                 reported = 0;

	// Scan the untaken candidates, keep best and runner-up, claim the winner if accepted
	function automatic match_t match_query(input logic [DESC_W-1:0] query);
		match_t m;
		int     span;
		int     best;
		int     second;
		int     best_at;
		int     ham;
		begin
			span    = (scan_count > MAX_CANDIDATES) ? MAX_CANDIDATES : int'(scan_count);
			best    = NO_DIST;
			second  = NO_DIST;
			best_at = 0;
			for (int i = 0; i < span; i++) begin
				if (!cand_taken[i]) begin
					ham = $countones(query ^ cand_desc[i]);
					if (ham < best) begin
						second  = best;
						best    = ham;
						best_at = i;
					end else if (ham < second) begin
						second = ham;
					end
				end
			end
			m.best_index      = best_at[INDEX_W-1:0];
			m.best_distance   = best[DIST_W-1:0];
			m.second_distance = second[DIST_W-1:0];
			m.found           = (best < int'(NO_DIST));
			m.accepted        = m.found && (best < int'(dist_limit)) &&
				(ratio == 0 || second > int'(ratio) * best);
			if (m.accepted)
				cand_taken[best_at] = 1'b1;
			match_query = m;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_count = ACTIVE_COUNT_RST;
			dist_limit = DISTANCE_LIMIT_RST;
			ratio      = RATIO_MULT_RST;
			pending_matches.delete();
			open_queries <= 0;
		end else begin
			// compare a delivered result word with the oldest prediction
			if (results.valid && results.ready) begin
				seen = '{results.best_index, results.best_distance, results.second_distance,
					results.found, results.accepted};
				if (pending_matches.size() == 0) begin
					failures++;
					if (reported < 10) begin
						reported++;
						$display("%0t: result word with no query outstanding: idx %0d best %0d",
							$time, seen.best_index, seen.best_distance);
					end
				end else begin
					want = pending_matches.pop_front();
					if (seen !== want) begin
						failures++;
						if (reported < 10) begin
							reported++;
							$display("%0t: mismatch, expected idx %0d best %0d 2nd %0d fnd %0b acc %0b",
								$time, want.best_index, want.best_distance,
								want.second_distance, want.found, want.accepted);
							$display("%0t:                got idx %0d best %0d 2nd %0d fnd %0b acc %0b",
								$time, seen.best_index, seen.best_distance,
								seen.second_distance, seen.found, seen.accepted);
						end
					end
				end
			end

			// store a load word, predict a query word
			if (items.valid && items.ready) begin
				if (items.mode == MODE_LOAD) begin
					if (items.slot < MAX_CANDIDATES) begin
						cand_desc[items.slot]  = {items.desc_w3, items.desc_w2, items.desc_w1,
							items.desc_w0};
						cand_taken[items.slot] = items.taken_in;
					end
				end else begin
					predicted = match_query({items.desc_w3, items.desc_w2,
						items.desc_w1, items.desc_w0});
					pending_matches = {pending_matches, predicted};
				end
			end

			// mirror register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_ACTIVE_COUNT:   scan_count = pwdata[COUNT_W-1:0];
					REG_DISTANCE_LIMIT: dist_limit = pwdata[LIMIT_W-1:0];
					REG_RATIO_MULT:     ratio      = pwdata[RATIO_W-1:0];
					default: ;
				endcase
			end

			fail_count   <= failures;
			open_queries <= pending_matches.size();
		end
	end

endmodule

>>> tb/sv/hamming_descriptor_matcher_tb.sv
`timescale 1ns / 1ps
// Top of the matcher testbench: clock, reset, load/query and register stimulus, and the
// verdict. Depends on hdm_pkg, the channel interfaces, the matcher and hdm_match_checker.

module hamming_descriptor_matcher_tb;
	import hdm_pkg::*;

	localparam int N_SLOTS = MAX_CANDIDATES_DEF;
	localparam int N_FILL  = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fail_count;
	int                    open_queries;
	bit                    calm;
	logic [DESC_W-1:0]     shadow [N_SLOTS];

	hdm_in_if  items_if();
	hdm_out_if results_if();

	hamming_descriptor_matcher uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if.sink),
		.results (results_if.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hdm_match_checker scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.items        (items_if),
		.results      (results_if),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.open_queries (open_queries)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// stall the result side now and then, never during the calm stretch
	always @(posedge clk) begin
		results_if.ready <= calm || ($urandom_range(99) >= 6);
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [DESC_W-1:0] rand_desc();
		rand_desc = {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	// flip a few random bits of a descriptor
	function automatic logic [DESC_W-1:0] perturb(input logic [DESC_W-1:0] d, input int flips);
		logic [DESC_W-1:0] r;
		int                pos;
		begin
			r = d;
			for (int k = 0; k < flips; k++) begin
				pos    = $urandom_range(DESC_W - 1);
				r[pos] = ~r[pos];
			end
			perturb = r;
		end
	endfunction

	// present one word, idling beforehand at random, and hold until taken
	task automatic send_word(input logic m, input logic [SLOT_W-1:0] s, input logic t,
		input logic [DESC_W-1:0] d);
		begin
			while (!calm && $urandom_range(99) < 6) begin
				items_if.valid <= 1'b0;
				@(posedge clk);
			end
			items_if.valid    <= 1'b1;
			items_if.mode     <= m;
			items_if.slot     <= s;
			items_if.taken_in <= t;
			items_if.desc_w0  <= d[63:0];
			items_if.desc_w1  <= d[127:64];
			items_if.desc_w2  <= d[191:128];
			items_if.desc_w3  <= d[255:192];
			@(posedge clk);
			while (!items_if.ready)
				@(posedge clk);
		end
	endtask

	task automatic load_slot(input int s, input logic t, input logic [DESC_W-1:0] d);
		begin
			send_word(MODE_LOAD, s[SLOT_W-1:0], t, d);
			shadow[s] = d;
		end
	endtask

	// slot and taken bits are don't-care on a query, so toggle them freely
	task automatic query(input logic [DESC_W-1:0] d);
		begin
			send_word(MODE_QUERY, SLOT_W'($urandom_range(N_SLOTS - 1)), 1'($urandom_range(1)),
				d);
		end
	endtask

	// drop valid and wait until every outstanding result word has been taken
	task automatic settle();
		begin
			items_if.valid <= 1'b0;
			do
				@(posedge clk);
			while (open_queries != 0);
			repeat (8) @(posedge clk);
		end
	endtask

	// setup then access phase; spare upper data bits carry noise
	task automatic apb_write(input logic [1:0] idx, input int width,
		input logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] junk;
		begin
			junk    = $urandom;
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {idx, 2'b00};
			pwdata  <= (junk << width) | value;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic configure(input int count, input int limit, input int rmult);
		begin
			settle();
			apb_write(REG_ACTIVE_COUNT, COUNT_W, count);
			apb_write(REG_DISTANCE_LIMIT, LIMIT_W, limit);
			apb_write(REG_RATIO_MULT, RATIO_W, rmult);
		end
	endtask

	initial begin
		int count;
		int span;
		int limit;
		int rmult;
		int pick;
		int s;

		arst_n            = 1'b0;
		calm              = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		items_if.valid    = 1'b0;
		items_if.mode     = MODE_LOAD;
		items_if.slot     = '0;
		items_if.taken_in = 1'b0;
		items_if.desc_w0  = '0;
		items_if.desc_w1  = '0;
		items_if.desc_w2  = '0;
		items_if.desc_w3  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty scan: nothing found
		configure(0, 30, 2);
		query('1);

		// small set: a zero word, an all-ones word, a taken copy of it, one bit off zero
		load_slot(0, 1'b0, '0);
		load_slot(1, 1'b0, '1);
		load_slot(2, 1'b1, '1);
		load_slot(3, 1'b0, {{(DESC_W-1){1'b0}}, 1'b1});
		configure(4, 30, 2);
		query('0);
		query('0);
		// only a candidate at full distance is left: still nothing found
		query('0);
		query('1);
		// every candidate taken
		query('1);

		// equal candidates: lower slot wins, zero best with zero runner-up fails the ratio
		load_slot(0, 1'b0, '0);
		load_slot(3, 1'b0, '0);
		query('0);
		configure(4, 30, 0);
		query('0);
		query('0);
		load_slot(0, 1'b0, '0);
		configure(4, 0, 15);
		query('0);
		configure(4, 257, 15);
		query('0);

		// fill the low slots so that any count up to the fill is safe to scan
		for (int i = 0; i < N_FILL; i++)
			load_slot(i, ($urandom_range(7) == 0), rand_desc());

		// scan the whole filled range
		configure(N_FILL, 60, 2);
		repeat (3) query(perturb(shadow[$urandom_range(N_FILL - 1)], $urandom_range(0, 30)));
		configure(N_FILL, 511, 0);
		repeat (2) query(perturb(shadow[$urandom_range(N_FILL - 1)], $urandom_range(0, 30)));

		// random phases: mostly queries near a stored candidate, some reloads and noise
		for (int p = 0; p < 10; p++) begin
			case (p)
				0:       count = 1;
				3:       count = N_FILL;
				7:       count = N_FILL;
				default: count = $urandom_range(2, 48);
			endcase
			case (p)
				1:       limit = 0;
				2:       limit = 257;
				5:       limit = 511;
				default: limit = $urandom_range(10, 120);
			endcase
			case (p)
				2:       rmult = 0;
				1, 4:    rmult = 15;
				default: rmult = $urandom_range(0, 4);
			endcase
			configure(count, limit, rmult);
			span = (count > N_SLOTS) ? N_SLOTS : count;
			calm = (p == 5 || p == 6);

			for (int n = 0; n < 32; n++) begin
				pick = $urandom_range(99);
				if (pick < 25) begin
					s = ($urandom_range(9) == 0) ? $urandom_range(N_SLOTS - 1)
						: $urandom_range(span - 1);
					if (pick < 12)
						load_slot(s, ($urandom_range(7) == 0),
							perturb(shadow[$urandom_range(span - 1)], $urandom_range(1, 20)));
					else
						load_slot(s, ($urandom_range(7) == 0), rand_desc());
				end else if (pick < 85) begin
					query(perturb(shadow[$urandom_range(span - 1)],
						($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40)));
				end else begin
					query(rand_desc());
				end
			end
		end
		calm = 1'b0;

		// drain and give the verdict
		settle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && open_queries == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> hamming_descriptor_matcher.f
src/hdm_pkg.sv
src/hdm_in_if.sv
src/hdm_out_if.sv
src/hdm_regs.sv
src/hdm_ctrl.sv
src/hdm_datapath.sv
src/hamming_descriptor_matcher.sv
tb/sv/hdm_match_checker.sv
tb/sv/hamming_descriptor_matcher_tb.sv
